// ----- hdl/ddme_pkg.sv -----
package ddme_pkg;

  // Fixed geometry of the two deques
  localparam int unsigned DEPTH   = 64;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
  localparam int unsigned POS_W   = $clog2(DEPTH);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic [1:0]                kind_t;
  typedef logic [3:0]                code_t;
  typedef logic [1:0]                status_t;
  typedef logic [1:0]                shift_t;

  // Item kinds
  localparam kind_t KIND_LOAD = 2'd0;
  localparam kind_t KIND_MOVE = 2'd1;
  localparam kind_t KIND_TAKE = 2'd2;

  // Move code bit positions
  localparam int unsigned CODE_SRC_RIGHT = 3;
  localparam int unsigned CODE_POP_BACK  = 2;
  localparam int unsigned CODE_DST_RIGHT = 1;
  localparam int unsigned CODE_PUSH_BACK = 0;

  // Result status
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Cell shift ops; "near" is the cell 0 end of a row
  localparam shift_t SH_HOLD     = 2'd0;
  localparam shift_t SH_TO_NEAR  = 2'd1;
  localparam shift_t SH_TO_FAR   = 2'd2;

  localparam count_t FULL_COUNT = COUNT_W'(DEPTH);

  // One row of cells: shift plus an optional write at one position
  typedef struct packed {
    shift_t shift;
    logic   wr_en;
    pos_t   wr_pos;
    value_t value;
  } cell_ctl_t;

  // Per-deque operation for one item
  typedef struct packed {
    logic   pop;
    logic   pop_back;
    logic   push;
    logic   push_back;
    value_t value;
  } deq_ctl_t;

  typedef struct packed {
    value_t front;
    value_t back;
    count_t fill;
  } deq_stat_t;

endpackage

// ----- hdl/ddme_if.sv -----
interface ddme_cmd_if;
  import ddme_pkg::*;

  logic   valid;
  logic   ready;
  kind_t  kind;
  code_t  code;
  logic   deck;
  value_t value;

  modport source (output valid, kind, code, deck, value, input ready);
  modport sink   (input valid, kind, code, deck, value, output ready);
endinterface

interface ddme_rsp_if;
  import ddme_pkg::*;

  logic    valid;
  logic    ready;
  value_t  taken_value;
  count_t  left_count;
  count_t  right_count;
  status_t status;

  modport source (output valid, taken_value, left_count, right_count, status, input ready);
  modport sink   (input valid, taken_value, left_count, right_count, status, output ready);
endinterface

// ----- hdl/ddme_cell.sv -----
module ddme_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk,
  input  ddme_pkg::cell_ctl_t ctl,
  input  ddme_pkg::value_t    from_near,
  input  ddme_pkg::value_t    from_far,
  output ddme_pkg::value_t    data
);
  import ddme_pkg::*;

  value_t data_next;

  always_comb begin
    case (ctl.shift)
      SH_TO_NEAR: data_next = from_far;
      SH_TO_FAR:  data_next = from_near;
      default:    data_next = data;
    endcase
    if (ctl.wr_en && (ctl.wr_pos == POS_W'(IDX))) begin
      data_next = ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ----- hdl/ddme_deque.sv -----
module ddme_deque (
  input  logic                clk,
  input  logic                rst,
  input  ddme_pkg::deq_ctl_t  ctl,
  output ddme_pkg::deq_stat_t stat
);
  import ddme_pkg::*;

  // Two rows hold the same contents: fwd_row has the front at cell 0,
  // rev_row has the back at cell 0, so both ends are read at fixed cells.
  value_t    fwd_row [DEPTH];
  value_t    rev_row [DEPTH];
  cell_ctl_t fwd_ctl;
  cell_ctl_t rev_ctl;
  count_t    fill;
  count_t    fill_next;

  function automatic cell_ctl_t row_ctl(input logic pop, input logic pop_near,
                                        input logic push, input logic push_near,
                                        input count_t cnt, input value_t v);
    cell_ctl_t c;
    c.shift = SH_HOLD;
    if (pop && pop_near && !(push && push_near)) begin
      c.shift = SH_TO_NEAR;
    end else if (push && push_near && !(pop && pop_near)) begin
      c.shift = SH_TO_FAR;
    end
    c.wr_en  = push;
    // far-end push lands just past the last entry left after any pop
    c.wr_pos = push_near ? '0 : POS_W'(cnt - COUNT_W'(pop));
    c.value  = v;
    return c;
  endfunction

  always_comb begin
    fwd_ctl   = row_ctl(ctl.pop, !ctl.pop_back, ctl.push, !ctl.push_back, fill, ctl.value);
    rev_ctl   = row_ctl(ctl.pop, ctl.pop_back, ctl.push, ctl.push_back, fill, ctl.value);
    fill_next = fill - COUNT_W'(ctl.pop) + COUNT_W'(ctl.push);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      value_t fwd_near, fwd_far, rev_near, rev_far;
      if (i == 0) begin : g_first
        assign fwd_near = ctl.value;
        assign rev_near = ctl.value;
      end else begin : g_mid
        assign fwd_near = fwd_row[i-1];
        assign rev_near = rev_row[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign fwd_far = fwd_row[i];
        assign rev_far = rev_row[i];
      end else begin : g_inner
        assign fwd_far = fwd_row[i+1];
        assign rev_far = rev_row[i+1];
      end

      ddme_cell #(.IDX(i)) u_fwd (
        .clk       (clk),
        .ctl       (fwd_ctl),
        .from_near (fwd_near),
        .from_far  (fwd_far),
        .data      (fwd_row[i])
      );

      ddme_cell #(.IDX(i)) u_rev (
        .clk       (clk),
        .ctl       (rev_ctl),
        .from_near (rev_near),
        .from_far  (rev_far),
        .data      (rev_row[i])
      );
    end
  endgenerate

  assign stat.front = fwd_row[0];
  assign stat.back  = rev_row[0];
  assign stat.fill  = fill;

endmodule

// ----- hdl/dual_deque_move_engine_top.sv -----
// Latency: an accepted item's result is valid on the next cycle, from the output register.
// Throughput: one item per cycle; a new item is taken whenever the output register is
//   empty or its result is being taken in the same cycle.
// Reset (rst, synchronous, active high): both deques empty, output register empty,
//   cmd.ready held low. Cell contents are not cleared; only filled cells are ever read.
module dual_deque_move_engine_top (
  input  logic              clk,
  input  logic              rst,
  ddme_cmd_if.sink          cmd,
  ddme_rsp_if.source        rsp
);
  import ddme_pkg::*;

  deq_ctl_t  left_ctl;
  deq_ctl_t  right_ctl;
  deq_stat_t left_stat;
  deq_stat_t right_stat;

  logic    accept;
  logic    rsp_valid;
  value_t  taken;
  value_t  taken_next;
  status_t status;
  status_t status_next;

  // move decode
  logic   src_right, pop_back, dst_right, push_back;
  count_t src_fill, dst_fill, deck_fill;
  value_t src_value;

  logic [COUNT_W:0] total;

  // New item only when the output slot is empty or frees up in this cycle.
  assign cmd.ready = !rst && (!rsp_valid || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;

  always_comb begin
    src_right = cmd.code[CODE_SRC_RIGHT];
    pop_back  = cmd.code[CODE_POP_BACK];
    dst_right = cmd.code[CODE_DST_RIGHT];
    push_back = cmd.code[CODE_PUSH_BACK];
    src_fill  = src_right ? right_stat.fill : left_stat.fill;
    dst_fill  = dst_right ? right_stat.fill : left_stat.fill;
    deck_fill = cmd.deck ? right_stat.fill : left_stat.fill;
    if (src_right) begin
      src_value = pop_back ? right_stat.back : right_stat.front;
    end else begin
      src_value = pop_back ? left_stat.back : left_stat.front;
    end

    left_ctl    = '0;
    right_ctl   = '0;
    taken_next  = '0;
    status_next = ST_DONE;

    case (cmd.kind)
      KIND_LOAD: begin
        if (deck_fill == FULL_COUNT) begin
          status_next = ST_FULL;
        end else if (cmd.deck) begin
          right_ctl.push      = 1'b1;
          right_ctl.push_back = 1'b1;
          right_ctl.value     = cmd.value;
        end else begin
          left_ctl.push      = 1'b1;
          left_ctl.push_back = 1'b1;
          left_ctl.value     = cmd.value;
        end
      end
      KIND_MOVE: begin
        if (src_fill == '0) begin
          status_next = ST_EMPTY;
        end else if ((src_right != dst_right) && (dst_fill == FULL_COUNT)) begin
          status_next = ST_FULL;
        end else begin
          // same-deque moves set pop and push on one deque; it resolves the net shift
          taken_next = src_value;
          if (src_right) begin
            right_ctl.pop      = 1'b1;
            right_ctl.pop_back = pop_back;
          end else begin
            left_ctl.pop      = 1'b1;
            left_ctl.pop_back = pop_back;
          end
          if (dst_right) begin
            right_ctl.push      = 1'b1;
            right_ctl.push_back = push_back;
            right_ctl.value     = src_value;
          end else begin
            left_ctl.push      = 1'b1;
            left_ctl.push_back = push_back;
            left_ctl.value     = src_value;
          end
        end
      end
      KIND_TAKE: begin
        if (deck_fill == '0) begin
          status_next = ST_EMPTY;
        end else begin
          taken_next = cmd.deck ? right_stat.front : left_stat.front;
          if (cmd.deck) begin
            right_ctl.pop = 1'b1;
          end else begin
            left_ctl.pop = 1'b1;
          end
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase

    // hold both deques unless an item is actually taken
    if (!accept) begin
      left_ctl.pop   = 1'b0;
      left_ctl.push  = 1'b0;
      right_ctl.pop  = 1'b0;
      right_ctl.push = 1'b0;
    end
  end

  ddme_deque u_left (
    .clk  (clk),
    .rst  (rst),
    .ctl  (left_ctl),
    .stat (left_stat)
  );

  ddme_deque u_right (
    .clk  (clk),
    .rst  (rst),
    .ctl  (right_ctl),
    .stat (right_stat)
  );

  // Output register. The fill counters only move when a new result is loaded,
  // so they serve directly as the result's counts while it waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      taken  <= taken_next;
      status <= status_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.taken_value = taken;
  assign rsp.left_count  = left_stat.fill;
  assign rsp.right_count = right_stat.fill;
  assign rsp.status      = status;

  assign total = {1'b0, left_stat.fill} + {1'b0, right_stat.fill};

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (left_stat.fill <= FULL_COUNT) && (right_stat.fill <= FULL_COUNT))
    else $error("deque fill beyond depth");

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (total == $past(total)) || (total == $past(total) + 1'b1) ||
               (total == $past(total) - 1'b1))
    else $error("total entries changed by more than one");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(left_stat.fill) && $stable(right_stat.fill))
    else $error("fill changed without an item");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status != ST_DONE)) |-> (taken == '0))
    else $error("ignored item reports a value");

endmodule
